FILE: src/sc1kd_pkg.sv
// ----------------------------------------------------------------------------
// sc1kd_pkg
// Shared types, scancode constants and the extended-key remap function for
// the set-1 scancode key decoder.
// ----------------------------------------------------------------------------
package sc1kd_pkg;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [7:0] LOW7_MASK   = 8'h7F;
    localparam logic [7:0] BREAK_BIT   = 8'h80;

    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_RSHIFT = 8'h36;
    localparam logic [7:0] SC_CAPS   = 8'h3A;
    localparam logic [7:0] SC_LCTRL  = 8'h1D;
    localparam logic [7:0] SC_LALT   = 8'h38;
    localparam logic [7:0] SC_RCTRL  = 8'h62;
    localparam logic [7:0] SC_RALT   = 8'h65;

    localparam logic [7:0] SC_LSHIFT_BRK = SC_LSHIFT | BREAK_BIT;
    localparam logic [7:0] SC_RSHIFT_BRK = SC_RSHIFT | BREAK_BIT;
    localparam logic [7:0] SC_CAPS_BRK   = SC_CAPS | BREAK_BIT;
    localparam logic [7:0] SC_LCTRL_BRK  = SC_LCTRL | BREAK_BIT;
    localparam logic [7:0] SC_LALT_BRK   = SC_LALT | BREAK_BIT;
    localparam logic [7:0] SC_RCTRL_BRK  = SC_RCTRL | BREAK_BIT;
    localparam logic [7:0] SC_RALT_BRK   = SC_RALT | BREAK_BIT;

    localparam int TDATA_W = 16;

    typedef struct packed {
        logic prefix_seen;
        logic lshift_down;
        logic rshift_down;
        logic lctrl_down;
        logic rctrl_down;
        logic lalt_down;
        logic ralt_down;
        logic caps_down;
        logic shift_flag;
        logic alt_flag;
        logic ctrl_flag;
        logic shift_toggle;
        logic alt_toggle;
    } t_kbd_state;

    typedef struct packed {
        logic       alt_lock;
        logic       shift_lock;
        logic       caps_active;
        logic       ctrl_active;
        logic       alt_active;
        logic       shift_active;
        logic [7:0] key_code;
    } t_key_result;

    // extended table: entry i maps to 0x61 + i, anything else to 0
    function automatic logic [6:0] ext_remap(input logic [6:0] low7);
        logic [6:0] res;
        res = 7'h00;
        case (low7)
            7'h1C: res = 7'h61;
            7'h1D: res = 7'h62;
            7'h35: res = 7'h63;
            7'h37: res = 7'h64;
            7'h38: res = 7'h65;
            7'h46: res = 7'h66;
            7'h47: res = 7'h67;
            7'h48: res = 7'h68;
            7'h49: res = 7'h69;
            7'h4B: res = 7'h6A;
            7'h4D: res = 7'h6B;
            7'h4F: res = 7'h6C;
            7'h50: res = 7'h6D;
            7'h51: res = 7'h6E;
            7'h52: res = 7'h6F;
            7'h53: res = 7'h70;
            default: res = 7'h00;
        endcase
        return res;
    endfunction

endpackage

FILE: src/scancode_set1_key_decoder.sv
// ----------------------------------------------------------------------------
// scancode_set1_key_decoder
// Set-1 scancode byte decoder with extended-key remap and modifier tracking.
//
// Input stream carries one raw scancode byte per transfer. Output stream
// carries one decoded key code together with the held-modifier flags and the
// shift/alt lock toggles. Prefix bytes and modifier make/break codes update
// internal state and produce no output transfer.
// A byte is captured in an input register, decoded combinationally and moved to
// the output register, which drives o_m_axis_tvalid; throughput is one byte per
// cycle while the output is not stalled. Bytes that produce no output drain even
// while the output is stalled; a byte that produces an output waits in the input
// register while the output register is full and not taken, and
// o_s_axis_tready drops until it moves on.
// Synchronous active-low reset clears the prefix, modifier and lock state
// and empties both registers.
// ----------------------------------------------------------------------------
module scancode_set1_key_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // scan_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // key_code[7:0], shift_active, alt_active, ctrl_active, caps_active,
    // shift_lock, alt_lock, zero padding[15:14]
    output logic [sc1kd_pkg::TDATA_W-1:0] o_m_axis_tdata
);

    logic                   r_in_vld;
    logic [7:0]             r_in_byte;
    logic                   r_out_vld;
    sc1kd_pkg::t_key_result r_out;
    sc1kd_pkg::t_key_result n_out;
    sc1kd_pkg::t_kbd_state  r_st;
    sc1kd_pkg::t_kbd_state  n_st;
    logic                   n_emit;
    logic [7:0]             code;
    logic                   advance;

    always_comb begin
        n_st   = r_st;
        n_emit = 1'b0;
        code   = r_in_byte;
        if (r_in_byte == sc1kd_pkg::PREFIX_BYTE) begin
            n_st.prefix_seen = 1'b1;
        end else begin
            if (r_st.prefix_seen) begin
                n_st.prefix_seen = 1'b0;
                code = {r_in_byte[7], sc1kd_pkg::ext_remap(r_in_byte[6:0])};
            end
            case (code)
                sc1kd_pkg::SC_LSHIFT: begin
                    n_st.lshift_down = 1'b1;
                    n_st.shift_flag  = 1'b1;
                end
                sc1kd_pkg::SC_LCTRL: begin
                    n_st.lctrl_down = 1'b1;
                    n_st.ctrl_flag  = 1'b1;
                end
                sc1kd_pkg::SC_LALT: begin
                    n_st.lalt_down = 1'b1;
                    n_st.alt_flag  = 1'b1;
                end
                sc1kd_pkg::SC_RSHIFT: begin
                    n_st.rshift_down = 1'b1;
                    n_st.shift_flag  = 1'b1;
                end
                sc1kd_pkg::SC_RCTRL: begin
                    n_st.rctrl_down = 1'b1;
                    n_st.ctrl_flag  = 1'b1;
                end
                sc1kd_pkg::SC_RALT: begin
                    n_st.ralt_down = 1'b1;
                    n_st.alt_flag  = 1'b1;
                end
                sc1kd_pkg::SC_CAPS: begin
                    // toggles only on first press, not on auto-repeat
                    if (!r_st.caps_down) begin
                        n_st.shift_toggle = r_st.shift_toggle ^ r_st.shift_flag;
                        n_st.alt_toggle   = r_st.alt_toggle ^ r_st.alt_flag;
                    end
                    n_st.caps_down = 1'b1;
                end
                sc1kd_pkg::SC_LSHIFT_BRK: begin
                    n_st.lshift_down = 1'b0;
                    n_st.shift_flag  = r_st.rshift_down;
                end
                sc1kd_pkg::SC_LCTRL_BRK: begin
                    n_st.lctrl_down = 1'b0;
                    n_st.ctrl_flag  = r_st.rctrl_down;
                end
                sc1kd_pkg::SC_LALT_BRK: begin
                    n_st.lalt_down = 1'b0;
                    n_st.alt_flag  = r_st.ralt_down;
                end
                sc1kd_pkg::SC_RSHIFT_BRK: begin
                    n_st.rshift_down = 1'b0;
                    n_st.shift_flag  = r_st.lshift_down;
                end
                sc1kd_pkg::SC_RCTRL_BRK: begin
                    n_st.rctrl_down = 1'b0;
                    n_st.ctrl_flag  = r_st.lctrl_down;
                end
                sc1kd_pkg::SC_RALT_BRK: begin
                    n_st.ralt_down = 1'b0;
                    n_st.alt_flag  = r_st.lalt_down;
                end
                sc1kd_pkg::SC_CAPS_BRK: begin
                    n_st.caps_down = 1'b0;
                end
                default: begin
                    n_emit = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        n_out.key_code     = code;
        n_out.shift_active = r_st.shift_flag;
        n_out.alt_active   = r_st.alt_flag;
        n_out.ctrl_active  = r_st.ctrl_flag;
        n_out.caps_active  = r_st.caps_down;
        n_out.shift_lock   = r_st.shift_toggle;
        n_out.alt_lock     = r_st.alt_toggle;
    end

    assign advance = r_in_vld && (!n_emit || !r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_st      <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_st <= n_st;
            end
            if (advance && n_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (advance && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_out};

endmodule

FILE: bench/scancode_set1_key_decoder_chk.sv
// ----------------------------------------------------------------------------
// scancode_set1_key_decoder_chk
// Watches both stream channels of the set-1 key decoder. Every accepted
// scancode byte is run through an independent model of the prefix, remap and
// modifier logic; each decoded key is queued and compared field by field with
// the next key transfer on the output. Mismatches and the number of keys
// still owed are handed back to the bench top.
// ----------------------------------------------------------------------------
module scancode_set1_key_decoder_chk (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [7:0]           i_s_tdata,   // scan_byte
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // key_code[7:0], shift_active, alt_active, ctrl_active, caps_active,
    // shift_lock, alt_lock, zero padding[15:14]
    input  logic [15:0]          i_m_tdata,
    output int                   o_errors,
    output int                   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [6:0] EXT_BASE = 7'h61;
    localparam logic [6:0] EXT_SOURCE [16] = '{
        7'h1C, 7'h1D, 7'h35, 7'h37, 7'h38, 7'h46, 7'h47, 7'h48,
        7'h49, 7'h4B, 7'h4D, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53
    };

    sc1kd_pkg::t_kbd_state  kbd = '0;
    sc1kd_pkg::t_key_result expected_keys[$];
    int                     mismatches = 0;

    function automatic logic [6:0] extended_key(input logic [6:0] low7);
        for (int i = 0; i < 16; i++) begin
            if (EXT_SOURCE[i] == low7) begin
                return EXT_BASE + 7'(i);
            end
        end
        return 7'h00;
    endfunction

    // updates the keyboard state, returns 1 when the byte yields a key
    function automatic bit decode_scan_byte(input logic [7:0] scan,
                                            output sc1kd_pkg::t_key_result key);
        logic [7:0] code;
        code = scan;
        key  = '0;
        if (scan == sc1kd_pkg::PREFIX_BYTE) begin
            kbd.prefix_seen = 1'b1;
            return 1'b0;
        end
        if (kbd.prefix_seen) begin
            kbd.prefix_seen = 1'b0;
            code = {scan[7], extended_key(scan[6:0])};
        end
        case (code)
            sc1kd_pkg::SC_LSHIFT: begin
                kbd.lshift_down = 1'b1;
                kbd.shift_flag  = 1'b1;
                return 1'b0;
            end
            sc1kd_pkg::SC_RSHIFT: begin
                kbd.rshift_down = 1'b1;
                kbd.shift_flag  = 1'b1;
                return 1'b0;
            end
            sc1kd_pkg::SC_LCTRL: begin
                kbd.lctrl_down = 1'b1;
                kbd.ctrl_flag  = 1'b1;
                return 1'b0;
            end
            sc1kd_pkg::SC_RCTRL: begin
                kbd.rctrl_down = 1'b1;
                kbd.ctrl_flag  = 1'b1;
                return 1'b0;
            end
            sc1kd_pkg::SC_LALT: begin
                kbd.lalt_down = 1'b1;
                kbd.alt_flag  = 1'b1;
                return 1'b0;
            end
            sc1kd_pkg::SC_RALT: begin
                kbd.ralt_down = 1'b1;
                kbd.alt_flag  = 1'b1;
                return 1'b0;
            end
            sc1kd_pkg::SC_CAPS: begin
                // auto-repeat leaves the locks alone
                if (!kbd.caps_down) begin
                    kbd.shift_toggle = kbd.shift_toggle ^ kbd.shift_flag;
                    kbd.alt_toggle   = kbd.alt_toggle ^ kbd.alt_flag;
                end
                kbd.caps_down = 1'b1;
                return 1'b0;
            end
            sc1kd_pkg::SC_LSHIFT_BRK: begin
                kbd.lshift_down = 1'b0;
                kbd.shift_flag  = kbd.rshift_down;
                return 1'b0;
            end
            sc1kd_pkg::SC_RSHIFT_BRK: begin
                kbd.rshift_down = 1'b0;
                kbd.shift_flag  = kbd.lshift_down;
                return 1'b0;
            end
            sc1kd_pkg::SC_LCTRL_BRK: begin
                kbd.lctrl_down = 1'b0;
                kbd.ctrl_flag  = kbd.rctrl_down;
                return 1'b0;
            end
            sc1kd_pkg::SC_RCTRL_BRK: begin
                kbd.rctrl_down = 1'b0;
                kbd.ctrl_flag  = kbd.lctrl_down;
                return 1'b0;
            end
            sc1kd_pkg::SC_LALT_BRK: begin
                kbd.lalt_down = 1'b0;
                kbd.alt_flag  = kbd.ralt_down;
                return 1'b0;
            end
            sc1kd_pkg::SC_RALT_BRK: begin
                kbd.ralt_down = 1'b0;
                kbd.alt_flag  = kbd.lalt_down;
                return 1'b0;
            end
            sc1kd_pkg::SC_CAPS_BRK: begin
                kbd.caps_down = 1'b0;
                return 1'b0;
            end
            default: begin
            end
        endcase
        key.key_code     = code;
        key.shift_active = kbd.shift_flag;
        key.alt_active   = kbd.alt_flag;
        key.ctrl_active  = kbd.ctrl_flag;
        key.caps_active  = kbd.caps_down;
        key.shift_lock   = kbd.shift_toggle;
        key.alt_lock     = kbd.alt_toggle;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        sc1kd_pkg::t_key_result want;
        sc1kd_pkg::t_key_result got;
        if (!i_rst_n) begin
            kbd = '0;
            expected_keys.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[$bits(sc1kd_pkg::t_key_result)-1:0];
                if (expected_keys.size() == 0) begin
                    $display("%0t: key transfer expected none, got %h", $time, i_m_tdata);
                    mismatches++;
                end else begin
                    want = expected_keys.pop_front();
                    check_field("key_code", want.key_code, got.key_code);
                    check_field("shift_active", 8'(want.shift_active), 8'(got.shift_active));
                    check_field("alt_active", 8'(want.alt_active), 8'(got.alt_active));
                    check_field("ctrl_active", 8'(want.ctrl_active), 8'(got.ctrl_active));
                    check_field("caps_active", 8'(want.caps_active), 8'(got.caps_active));
                    check_field("shift_lock", 8'(want.shift_lock), 8'(got.shift_lock));
                    check_field("alt_lock", 8'(want.alt_lock), 8'(got.alt_lock));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (decode_scan_byte(i_s_tdata, want)) begin
                    expected_keys.push_back(want);
                end
            end
        end
        o_errors      <= mismatches;
        o_outstanding <= expected_keys.size();
    end

endmodule

FILE: bench/scancode_set1_key_decoder_tb.sv
// ----------------------------------------------------------------------------
// scancode_set1_key_decoder_tb
// Feeds the set-1 key decoder a short directed run of modifier, lock, prefix
// and extended-key sequences, then about a thousand random scancode bytes,
// partly well-formed modifier and extended sequences. Both stream sides idle
// at random; one phase holds the output off long enough to stall the input.
// The checker beside the block predicts and compares every key transfer.
// ----------------------------------------------------------------------------
module scancode_set1_key_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_BYTES = 1050;
    localparam int LONG_HOLD   = 300;

    localparam logic [7:0] OPENING [27] = '{
        8'h00, 8'h7F, 8'hFF, 8'hE1,
        sc1kd_pkg::SC_LSHIFT, 8'h1E, sc1kd_pkg::SC_RSHIFT, sc1kd_pkg::SC_LSHIFT_BRK,
        sc1kd_pkg::SC_CAPS, sc1kd_pkg::SC_CAPS, 8'h1E, sc1kd_pkg::SC_CAPS_BRK,
        sc1kd_pkg::SC_RSHIFT_BRK,
        sc1kd_pkg::SC_LCTRL, sc1kd_pkg::PREFIX_BYTE, sc1kd_pkg::SC_LALT,
        sc1kd_pkg::SC_LCTRL_BRK, sc1kd_pkg::SC_RCTRL, 8'h1E, sc1kd_pkg::SC_RCTRL_BRK,
        sc1kd_pkg::PREFIX_BYTE, sc1kd_pkg::SC_LALT_BRK,
        sc1kd_pkg::PREFIX_BYTE, sc1kd_pkg::PREFIX_BYTE, 8'h81,
        sc1kd_pkg::PREFIX_BYTE, 8'hD3
    };

    localparam logic [7:0] MOD_KEYS [7] = '{
        sc1kd_pkg::SC_LSHIFT, sc1kd_pkg::SC_RSHIFT, sc1kd_pkg::SC_LCTRL,
        sc1kd_pkg::SC_LALT, sc1kd_pkg::SC_CAPS, sc1kd_pkg::SC_RCTRL, sc1kd_pkg::SC_RALT
    };

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = 8'h00;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [15:0] m_data;
    logic        hold_req = 1'b0;
    bit          src_steady  = 1'b0;
    bit          sink_steady = 1'b0;
    int          sent = 0;
    int          err_count;
    int          outstanding;

    scancode_set1_key_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    scancode_set1_key_decoder_chk chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_valid),
        .i_s_tready    (s_ready),
        .i_s_tdata     (s_data),
        .i_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (m_data),
        .o_errors      (err_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("scancode_set1_key_decoder_tb: errors");
        $finish;
    end

    // key receiver
    initial begin : sink
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready  <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = sink_steady ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!m_valid);
        end
    end

    task automatic send_byte(input logic [7:0] scan);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= scan;
        do @(posedge clk); while (!s_ready);
        sent++;
    endtask

    // stop offering and wait until every decoded key has been taken
    task automatic drain_keys();
        s_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic send_random(input int upto);
        int         sel;
        logic [7:0] scan;
        while (sent < upto) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                scan = MOD_KEYS[$urandom_range(0, 6)];
                // prefixed left ctrl/alt become the right-hand keys
                if ((scan == sc1kd_pkg::SC_LCTRL || scan == sc1kd_pkg::SC_LALT)
                        && $urandom_range(0, 1) == 1) begin
                    send_byte(sc1kd_pkg::PREFIX_BYTE);
                end
                send_byte(scan | ($urandom_range(0, 1) == 1 ? sc1kd_pkg::BREAK_BIT : 8'h00));
            end else if (sel < 50) begin
                send_byte(sc1kd_pkg::PREFIX_BYTE);
                if ($urandom_range(0, 9) == 0) begin
                    send_byte(sc1kd_pkg::PREFIX_BYTE);
                end
                scan = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(8'h1C, 8'h53))
                                                   : 8'($urandom_range(0, 255));
                scan[7] = 1'($urandom_range(0, 1));
                send_byte(scan);
            end else if (sel < 53) begin
                send_byte(sc1kd_pkg::PREFIX_BYTE);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING[i]) begin
            send_byte(OPENING[i]);
        end

        send_random(450);

        // output held off while keys keep coming
        src_steady = 1'b1;
        hold_req  <= 1'b1;
        repeat (60) send_byte(8'($urandom_range(8'h02, 8'h0B)));
        src_steady = 1'b0;
        drain_keys();

        src_steady  = 1'b1;
        sink_steady = 1'b1;
        send_random(700);
        src_steady  = 1'b0;
        sink_steady = 1'b0;

        send_random(TOTAL_BYTES);
        drain_keys();
        repeat (8) @(posedge clk);

        if (err_count == 0 && outstanding == 0) begin
            $display("scancode_set1_key_decoder_tb: clean");
        end else begin
            $display("scancode_set1_key_decoder_tb: errors");
        end
        $finish;
    end

endmodule
